// ===== rtl/alp_pkg.sv =====
// Shared types, widths, codes and reset values for the address lease pool.
// Used by every module of the block; no dependencies.
package alp_pkg;

  localparam int POOL_ENTRIES_DEF = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ADDR_W     = 32;
  localparam int TIME_W     = 32;
  localparam int LEASE_W    = 16;
  localparam int USE_W      = 4;
  localparam int CMD_W      = 2;
  localparam int CLS_W      = 2;
  localparam int WANT_W     = 3;
  localparam int PORT_W     = 8;
  localparam int REPLY_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_SHORT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_MEDIUM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEASE_LONG     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS   = 3'd4;

  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DISCOVER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REQUEST  = 2'd2;

  localparam logic [CLS_W-1:0] CLS_SENSOR  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_DESKTOP = 2'd1;

  localparam logic [REPLY_W-1:0] RPL_OFFER   = 2'd0;
  localparam logic [REPLY_W-1:0] RPL_ACK     = 2'd1;
  localparam logic [REPLY_W-1:0] RPL_DENIED  = 2'd2;
  localparam logic [REPLY_W-1:0] RPL_IGNORED = 2'd3;

  localparam logic [LEASE_W-1:0] LEASE_SHORT_RST    = 16'd10;
  localparam logic [LEASE_W-1:0] LEASE_MEDIUM_RST   = 16'd30;
  localparam logic [LEASE_W-1:0] LEASE_LONG_RST     = 16'd60;
  localparam logic [USE_W-1:0]   ENTRIES_IN_USE_RST = 4'd3;
  localparam logic [ADDR_W-1:0]  BASE_ADDRESS_RST   = 32'd3232235786;

  typedef struct packed {
    logic [LEASE_W-1:0] lease_short;
    logic [LEASE_W-1:0] lease_medium;
    logic [LEASE_W-1:0] lease_long;
    logic [USE_W-1:0]   entries_in_use;
    logic [ADDR_W-1:0]  base_address;
  } alp_cfg_t;

  function automatic logic [LEASE_W-1:0] lease_for(alp_cfg_t cfg, logic [CLS_W-1:0] cls);
    logic [LEASE_W-1:0] lease;
    case (cls)
      CLS_SENSOR:  lease = cfg.lease_short;
      CLS_DESKTOP: lease = cfg.lease_medium;
      default:     lease = cfg.lease_long;
    endcase
    return lease;
  endfunction

endpackage

// ===== rtl/address_lease_pool_core.sv =====
// Address lease pool: configuration registers, expiry store and lease sequencer.
// Depends on alp_pkg, alp_expiry_mem and alp_engine.
//
// A tick or a discover walks every pool entry through the single read port of the
// expiry store, one entry per cycle, freeing leases that have run out; after a
// discover the lowest free usable entry is granted. A request is checked against
// the active bits at once; an unknown command is dropped. One transaction is
// worked at a time; the result register lets the next transaction start while a
// reply still waits. Expiry values need no clearing after reset: an entry's value
// is used only while its active bit, cleared by reset, is set.
module address_lease_pool_core #(
  parameter int POOL_ENTRIES = alp_pkg::POOL_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [alp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [alp_pkg::CMD_W-1:0]      command,
  input  logic [alp_pkg::CLS_W-1:0]      device_class,
  input  logic [alp_pkg::WANT_W-1:0]     wanted_index,
  input  logic [alp_pkg::PORT_W-1:0]     client_port,
  input  logic [alp_pkg::LEASE_W-1:0]    asked_lease,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [alp_pkg::REPLY_W-1:0]    reply,
  output logic [alp_pkg::ADDR_W-1:0]     address,
  output logic [alp_pkg::WANT_W-1:0]     entry_index,
  output logic [alp_pkg::LEASE_W-1:0]    lease_seconds,
  output logic [alp_pkg::CLS_W-1:0]      reply_class,
  output logic [alp_pkg::PORT_W-1:0]     reply_port
);
  import alp_pkg::*;

  localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;

  alp_cfg_t          cfg;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [TIME_W-1:0] mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;
  logic [TIME_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lease_short    <= LEASE_SHORT_RST;
      cfg.lease_medium   <= LEASE_MEDIUM_RST;
      cfg.lease_long     <= LEASE_LONG_RST;
      cfg.entries_in_use <= ENTRIES_IN_USE_RST;
      cfg.base_address   <= BASE_ADDRESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEASE_SHORT:    cfg.lease_short    <= cfg_data[LEASE_W-1:0];
        CFG_LEASE_MEDIUM:   cfg.lease_medium   <= cfg_data[LEASE_W-1:0];
        CFG_LEASE_LONG:     cfg.lease_long     <= cfg_data[LEASE_W-1:0];
        CFG_ENTRIES_IN_USE: cfg.entries_in_use <= cfg_data[USE_W-1:0];
        CFG_BASE_ADDRESS:   cfg.base_address   <= cfg_data[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  alp_expiry_mem #(
    .DEPTH (POOL_ENTRIES),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  alp_engine #(
    .POOL_ENTRIES (POOL_ENTRIES),
    .IDX_W        (IDX_W)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .device_class  (device_class),
    .wanted_index  (wanted_index),
    .client_port   (client_port),
    .asked_lease   (asked_lease),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .reply         (reply),
    .address       (address),
    .entry_index   (entry_index),
    .lease_seconds (lease_seconds),
    .reply_class   (reply_class),
    .reply_port    (reply_port),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

endmodule

// ===== rtl/alp_expiry_mem.sv =====
// Expiry second store: one write port, one read port, registered read data.
// Depends on alp_pkg for the time width.
module alp_expiry_mem #(
  parameter int DEPTH = alp_pkg::POOL_ENTRIES_DEF,
  parameter int IDX_W = 3
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [IDX_W-1:0]          waddr,
  input  logic [alp_pkg::TIME_W-1:0] wdata,
  input  logic [IDX_W-1:0]          raddr,
  output logic [alp_pkg::TIME_W-1:0] rdata
);
  import alp_pkg::*;

  logic [TIME_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/alp_engine.sv =====
// Lease sequencer: seconds counter, active bits, expiry sweep, allocation,
// renewal and the result register. Depends on alp_pkg; reads an expiry store with registered read data.
module alp_engine #(
  parameter int POOL_ENTRIES = alp_pkg::POOL_ENTRIES_DEF,
  parameter int IDX_W        = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  alp_pkg::alp_cfg_t           cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [alp_pkg::CMD_W-1:0]   command,
  input  logic [alp_pkg::CLS_W-1:0]   device_class,
  input  logic [alp_pkg::WANT_W-1:0]  wanted_index,
  input  logic [alp_pkg::PORT_W-1:0]  client_port,
  input  logic [alp_pkg::LEASE_W-1:0] asked_lease,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [alp_pkg::REPLY_W-1:0] reply,
  output logic [alp_pkg::ADDR_W-1:0]  address,
  output logic [alp_pkg::WANT_W-1:0]  entry_index,
  output logic [alp_pkg::LEASE_W-1:0] lease_seconds,
  output logic [alp_pkg::CLS_W-1:0]   reply_class,
  output logic [alp_pkg::PORT_W-1:0]  reply_port,
  output logic                        mem_we,
  output logic [IDX_W-1:0]            mem_waddr,
  output logic [alp_pkg::TIME_W-1:0]  mem_wdata,
  output logic [IDX_W-1:0]            mem_raddr,
  input  logic [alp_pkg::TIME_W-1:0]  mem_rdata
);
  import alp_pkg::*;

  localparam int CNT_W = $clog2(POOL_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > USE_W) ? CNT_W : USE_W;
  localparam int CAP   = (POOL_ENTRIES < 15) ? POOL_ENTRIES : 15;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_FIN   = 3'b100
  } state_t;

  state_t                  state;
  logic [TIME_W-1:0]       now;
  logic [POOL_ENTRIES-1:0] active;
  logic [CNT_W-1:0]        scan;
  logic                    pending;
  logic [IDX_W-1:0]        pend_idx;
  logic                    found;
  logic [IDX_W-1:0]        found_idx;
  logic [CMD_W-1:0]        cmd_q;
  logic [CLS_W-1:0]        cls_q;
  logic [PORT_W-1:0]       port_q;

  logic [REPLY_W-1:0]      res_reply;
  logic [ADDR_W-1:0]       res_address;
  logic [WANT_W-1:0]       res_index;
  logic [LEASE_W-1:0]      res_lease;
  logic [CLS_W-1:0]        res_class;
  logic [PORT_W-1:0]       res_port;

  logic [USE_W-1:0]        bound;
  logic [IDX_W-1:0]        want_idx;
  logic                    req_hit;
  logic                    in_acc;
  logic [LEASE_W-1:0]      lease_in;
  logic [LEASE_W-1:0]      lease_q;
  logic [TIME_W-1:0]       diff;
  logic                    expired;
  logic                    free_here;
  logic                    pend_in_range;
  logic                    scan_done;
  logic                    sweep_end;

  assign bound    = (cfg.entries_in_use < USE_W'(CAP)) ? cfg.entries_in_use : USE_W'(CAP);
  assign want_idx = IDX_W'(wanted_index);
  assign req_hit  = (USE_W'(wanted_index) < bound) && active[want_idx];
  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign lease_in = lease_for(cfg, device_class);
  assign lease_q  = lease_for(cfg, cls_q);

  assign diff          = now - mem_rdata;
  assign expired       = pending && active[pend_idx] && !diff[TIME_W-1];
  assign free_here     = pending && (!active[pend_idx] || expired);
  assign pend_in_range = CMP_W'(pend_idx) < CMP_W'(bound);
  assign scan_done     = (scan == CNT_W'(POOL_ENTRIES));
  assign sweep_end     = (state == ST_SWEEP) && scan_done && !pending;

  assign mem_raddr = scan[IDX_W-1:0];
  assign mem_we    = (in_acc && command == CMD_REQUEST && req_hit) ||
                     (sweep_end && cmd_q == CMD_DISCOVER && found);
  assign mem_waddr = in_acc ? want_idx : found_idx;
  assign mem_wdata = in_acc ? now + TIME_W'(lease_in) : now + TIME_W'(lease_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      now       <= '0;
      active    <= '0;
      scan      <= '0;
      pending   <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_FIN && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            cmd_q  <= command;
            cls_q  <= device_class;
            port_q <= client_port;
            case (command)
              CMD_TICK: begin
                now   <= now + TIME_W'(1);
                scan  <= '0;
                found <= 1'b0;
                state <= ST_SWEEP;
              end
              CMD_DISCOVER: begin
                scan  <= '0;
                found <= 1'b0;
                state <= ST_SWEEP;
              end
              CMD_REQUEST: begin
                res_class <= device_class;
                res_port  <= client_port;
                res_index <= wanted_index;
                if (req_hit) begin
                  res_reply   <= RPL_ACK;
                  res_address <= cfg.base_address + ADDR_W'(wanted_index);
                  res_lease   <= asked_lease;
                end else begin
                  res_reply   <= RPL_IGNORED;
                  res_address <= '0;
                  res_lease   <= '0;
                end
                state <= ST_FIN;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SWEEP: begin
          if (!scan_done) begin
            scan     <= scan + CNT_W'(1);
            pending  <= 1'b1;
            pend_idx <= scan[IDX_W-1:0];
          end else begin
            pending <= 1'b0;
          end
          if (expired) begin
            active[pend_idx] <= 1'b0;
          end
          if (free_here && pend_in_range && !found) begin
            found     <= 1'b1;
            found_idx <= pend_idx;
          end
          if (sweep_end) begin
            if (cmd_q == CMD_TICK) begin
              state <= ST_IDLE;
            end else begin
              res_class <= cls_q;
              res_port  <= port_q;
              if (found) begin
                active[found_idx] <= 1'b1;
                res_reply         <= RPL_OFFER;
                res_address       <= cfg.base_address + ADDR_W'(found_idx);
                res_index         <= WANT_W'(found_idx);
                res_lease         <= lease_q;
              end else begin
                res_reply   <= RPL_DENIED;
                res_address <= '0;
                res_index   <= '0;
                res_lease   <= '0;
              end
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && (!out_valid || out_ready)) begin
      reply         <= res_reply;
      address       <= res_address;
      entry_index   <= res_index;
      lease_seconds <= res_lease;
      reply_class   <= res_class;
      reply_port    <= res_port;
    end
  end

endmodule
